// ===== hdl/sbc_pkg.sv =====
package sbc_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 20;

  localparam int RADIUS_W  = 19;
  localparam int ACTIVE_W  = 7;
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOM_X_LOW  = 3'd0,
    REG_ROOM_X_HIGH = 3'd1,
    REG_ROOM_Y_LOW  = 3'd2,
    REG_ROOM_Y_HIGH = 3'd3,
    REG_ROOM_Z_LOW  = 3'd4,
    REG_ROOM_Z_HIGH = 3'd5,
    REG_RADIUS      = 3'd6,
    REG_ACTIVE      = 3'd7
  } cfg_reg_t;

endpackage

// ===== hdl/sbc_ram.sv =====
module sbc_ram import sbc_pkg::*; #(
  parameter int WIDTH = 6 * COORD_BITS_DEF,
  parameter int DEPTH = MAX_BOXES_DEF
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sbc_frac_cmp.sv =====
module sbc_frac_cmp import sbc_pkg::*; #(
  parameter int NW = COORD_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic [NW-1:0] n1,
  input  logic [NW-1:0] d1,
  input  logic [NW-1:0] n2,
  input  logic [NW-1:0] d2,
  output logic          gt
);

  logic [2*NW-1:0] p1_r, p2_r;

  always_ff @(posedge clk) begin
    p1_r <= n1 * d2;
    p2_r <= n2 * d1;
  end

  assign gt = p1_r > p2_r;

endmodule

// ===== hdl/segment_box_collision_check.sv =====
// Load transaction: table row written at the accepting edge, no result.
// Query transaction: result strobes in the cycle after the last step; direct from idle
// when an endpoint is in the wall band or no boxes are active, else up to one table read per
// active box, then per axis a setup and, for a moving axis, near, far and cross steps on
// the shared fraction multiplier; busy stays high meanwhile. Synchronous active low reset
// idles the sequencer, restores only config registers and out_valid; no result stall.
module segment_box_collision_check import sbc_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [SLOT_W-1:0]                     in_box_slot,
  input  logic signed [COORD_BITS-1:0]          in_x_a,
  input  logic signed [COORD_BITS-1:0]          in_y_a,
  input  logic signed [COORD_BITS-1:0]          in_z_a,
  input  logic signed [COORD_BITS-1:0]          in_x_b,
  input  logic signed [COORD_BITS-1:0]          in_y_b,
  input  logic signed [COORD_BITS-1:0]          in_z_b,
  output logic                                  out_valid,
  output logic                                  out_collided,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [((COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W)-1:0] cfg_data
);

  localparam int C  = COORD_BITS;
  localparam int EW = ((C > RADIUS_W + 1) ? C : RADIUS_W + 1) + 2;
  localparam int DW = C + 1;
  localparam int NW = C + 1;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int RW = 6 * C;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_AXIS,
    S_MUL_NEAR,
    S_MUL_FAR,
    S_UPD_FAR,
    S_MUL_CROSS,
    S_CHK_CROSS
  } state_t;

  logic signed [C-1:0] room_lo_r [3];
  logic signed [C-1:0] room_hi_r [3];
  logic [RADIUS_W-1:0] radius_r;
  logic [ACTIVE_W-1:0] active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        room_lo_r[k] <= {1'b1, {(C-1){1'b0}}};
        room_hi_r[k] <= {1'b0, {(C-1){1'b1}}};
      end
      radius_r <= '0;
      active_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROOM_X_LOW:  room_lo_r[0] <= cfg_data[C-1:0];
        REG_ROOM_X_HIGH: room_hi_r[0] <= cfg_data[C-1:0];
        REG_ROOM_Y_LOW:  room_lo_r[1] <= cfg_data[C-1:0];
        REG_ROOM_Y_HIGH: room_hi_r[1] <= cfg_data[C-1:0];
        REG_ROOM_Z_LOW:  room_lo_r[2] <= cfg_data[C-1:0];
        REG_ROOM_Z_HIGH: room_hi_r[2] <= cfg_data[C-1:0];
        REG_RADIUS:      radius_r     <= cfg_data[RADIUS_W-1:0];
        REG_ACTIVE:      active_r     <= cfg_data[ACTIVE_W-1:0];
      endcase
    end
  end

  logic signed [EW-1:0] r_e;
  assign r_e = EW'({1'b0, radius_r});

  function automatic logic in_band(logic signed [EW-1:0] p, logic signed [EW-1:0] lo,
                                   logic signed [EW-1:0] hi, logic signed [EW-1:0] r);
    return (p <= lo + r) || (p >= hi - r);
  endfunction

  logic signed [C-1:0] pa [3];
  logic signed [C-1:0] pb [3];
  logic                wall_hit;

  assign pa[0] = in_x_a;
  assign pa[1] = in_y_a;
  assign pa[2] = in_z_a;
  assign pb[0] = in_x_b;
  assign pb[1] = in_y_b;
  assign pb[2] = in_z_b;

  always_comb begin
    wall_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (in_band(EW'(pa[k]), EW'(room_lo_r[k]), EW'(room_hi_r[k]), r_e) ||
          in_band(EW'(pb[k]), EW'(room_lo_r[k]), EW'(room_hi_r[k]), r_e)) begin
        wall_hit = 1'b1;
      end
    end
  end

  logic          accept;
  logic          slot_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [RW-1:0] row;
  logic [CW-1:0] box_lim;

  state_t               state_r, state_nxt;
  logic signed [C-1:0]  a_r [3];
  logic signed [C-1:0]  a_nxt [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] d_nxt [3];
  logic [CW-1:0]        box_idx_r, box_idx_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [NW-1:0]        tn_r, tn_nxt, tx_r, tx_nxt, dn_r, dn_nxt;
  logic [NW-1:0]        near_n_r, near_n_nxt, near_d_r, near_d_nxt;
  logic [NW-1:0]        far_n_r, far_n_nxt, far_d_r, far_d_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_collided_r, out_collided_nxt;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = {{(32-SLOT_W){1'b0}}, in_box_slot} < 32'(MAX_BOXES);
  assign ram_we  = accept && (in_kind == KIND_LOAD) && slot_ok;
  assign ram_waddr = AW'(in_box_slot);
  assign ram_wdata = {in_z_b, in_z_a, in_y_b, in_y_a, in_x_b, in_x_a};
  assign ram_re    = (state_r == S_READ);
  assign box_lim   = ({{(32-ACTIVE_W){1'b0}}, active_r} > 32'(MAX_BOXES)) ?
                     CW'(MAX_BOXES) : CW'(active_r);

  sbc_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_BOXES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (box_idx_r[AW-1:0]),
    .rdata (row)
  );

  logic [NW-1:0] fc_n1, fc_d1, fc_n2, fc_d2;
  logic          fc_gt;

  always_comb begin
    unique case (state_r)
      S_MUL_FAR: begin
        fc_n1 = far_n_r;
        fc_d1 = far_d_r;
        fc_n2 = tx_r;
        fc_d2 = dn_r;
      end
      S_MUL_CROSS: begin
        fc_n1 = near_n_r;
        fc_d1 = near_d_r;
        fc_n2 = far_n_r;
        fc_d2 = far_d_r;
      end
      default: begin
        fc_n1 = tn_r;
        fc_d1 = dn_r;
        fc_n2 = near_n_r;
        fc_d2 = near_d_r;
      end
    endcase
  end

  sbc_frac_cmp #(
    .NW (NW)
  ) u_frac (
    .clk (clk),
    .n1  (fc_n1),
    .d1  (fc_d1),
    .n2  (fc_n2),
    .d2  (fc_d2),
    .gt  (fc_gt)
  );

  logic signed [C-1:0]  lo_raw, hi_raw, o_sel;
  logic signed [DW-1:0] d_sel;
  logic signed [EW-1:0] lo_e, hi_e, o_e, n1, n2, n1s, n2s, den_e, tmin, tmax;
  logic                 axis_still, out_of_bounds, slab_miss;
  logic [CW-1:0]        box_idx_inc;

  always_comb begin
    unique case (axis_r)
      2'd0: begin
        o_sel = a_r[0];
        d_sel = d_r[0];
      end
      2'd1: begin
        o_sel = a_r[1];
        d_sel = d_r[1];
      end
      default: begin
        o_sel = a_r[2];
        d_sel = d_r[2];
      end
    endcase
    lo_raw = row[(2 * axis_r) * C +: C];
    hi_raw = row[(2 * axis_r + 1) * C +: C];
    lo_e   = EW'(lo_raw) - r_e;
    hi_e   = EW'(hi_raw) + r_e;
    o_e    = EW'(o_sel);
    axis_still    = (d_sel == '0);
    out_of_bounds = (o_e < lo_e) || (o_e > hi_e);
    n1     = lo_e - o_e;
    n2     = hi_e - o_e;
    n1s    = d_sel[DW-1] ? -n1 : n1;
    n2s    = d_sel[DW-1] ? -n2 : n2;
    den_e  = d_sel[DW-1] ? -EW'(d_sel) : EW'(d_sel);
    tmin   = (n1s < n2s) ? n1s : n2s;
    tmax   = (n1s < n2s) ? n2s : n1s;
    slab_miss   = (tmin > den_e) || tmax[EW-1];
    box_idx_inc = CW'(box_idx_r + 1'b1);
  end

  always_comb begin
    state_nxt        = state_r;
    a_nxt            = a_r;
    d_nxt            = d_r;
    box_idx_nxt      = box_idx_r;
    axis_nxt         = axis_r;
    tn_nxt           = tn_r;
    tx_nxt           = tx_r;
    dn_nxt           = dn_r;
    near_n_nxt       = near_n_r;
    near_d_nxt       = near_d_r;
    far_n_nxt        = far_n_r;
    far_d_nxt        = far_d_r;
    out_valid_nxt    = 1'b0;
    out_collided_nxt = out_collided_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_QUERY)) begin
          for (int k = 0; k < 3; k++) begin
            a_nxt[k] = pa[k];
            d_nxt[k] = DW'(pb[k]) - DW'(pa[k]);
          end
          box_idx_nxt = '0;
          if (wall_hit || (box_lim == '0)) begin
            out_valid_nxt    = 1'b1;
            out_collided_nxt = wall_hit;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        axis_nxt   = 2'd0;
        near_n_nxt = '0;
        near_d_nxt = NW'(1);
        far_n_nxt  = NW'(1);
        far_d_nxt  = NW'(1);
        state_nxt  = S_AXIS;
      end
      S_AXIS: begin
        if (axis_still) begin
          if (out_of_bounds) begin
            if (box_idx_inc == box_lim) begin
              out_valid_nxt    = 1'b1;
              out_collided_nxt = 1'b0;
              state_nxt        = S_IDLE;
            end else begin
              box_idx_nxt = box_idx_inc;
              state_nxt   = S_READ;
            end
          end else if (axis_r == 2'd2) begin
            out_valid_nxt    = 1'b1;
            out_collided_nxt = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else if (slab_miss) begin
          if (box_idx_inc == box_lim) begin
            out_valid_nxt    = 1'b1;
            out_collided_nxt = 1'b0;
            state_nxt        = S_IDLE;
          end else begin
            box_idx_nxt = box_idx_inc;
            state_nxt   = S_READ;
          end
        end else begin
          tn_nxt    = tmin[EW-1] ? '0 : NW'(tmin);
          tx_nxt    = (tmax > den_e) ? NW'(den_e) : NW'(tmax);
          dn_nxt    = NW'(den_e);
          state_nxt = S_MUL_NEAR;
        end
      end
      S_MUL_NEAR: begin
        state_nxt = S_MUL_FAR;
      end
      S_MUL_FAR: begin
        if (fc_gt) begin
          near_n_nxt = tn_r;
          near_d_nxt = dn_r;
        end
        state_nxt = S_UPD_FAR;
      end
      S_UPD_FAR: begin
        if (fc_gt) begin
          far_n_nxt = tx_r;
          far_d_nxt = dn_r;
        end
        state_nxt = S_MUL_CROSS;
      end
      S_MUL_CROSS: begin
        state_nxt = S_CHK_CROSS;
      end
      S_CHK_CROSS: begin
        if (fc_gt) begin
          if (box_idx_inc == box_lim) begin
            out_valid_nxt    = 1'b1;
            out_collided_nxt = 1'b0;
            state_nxt        = S_IDLE;
          end else begin
            box_idx_nxt = box_idx_inc;
            state_nxt   = S_READ;
          end
        end else if (axis_r == 2'd2) begin
          out_valid_nxt    = 1'b1;
          out_collided_nxt = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_AXIS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r            <= a_nxt;
    d_r            <= d_nxt;
    box_idx_r      <= box_idx_nxt;
    axis_r         <= axis_nxt;
    tn_r           <= tn_nxt;
    tx_r           <= tx_nxt;
    dn_r           <= dn_nxt;
    near_n_r       <= near_n_nxt;
    near_d_r       <= near_d_nxt;
    far_n_r        <= far_n_nxt;
    far_d_r        <= far_d_nxt;
    out_collided_r <= out_collided_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_collided = out_collided_r;

endmodule

// ===== bench/segment_box_collision_check_test.sv =====
`timescale 1ns / 100ps

module segment_box_collision_check_test;
  import sbc_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int CFG_W       = (COORD_BITS_DEF > RADIUS_W) ? COORD_BITS_DEF : RADIUS_W;
  localparam int N_BOXES     = MAX_BOXES_DEF;
  localparam int COORD_MIN   = -(1 << (COORD_W - 1));
  localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
  localparam int RADIUS_MAX  = (1 << RADIUS_W) - 1;
  localparam int ACTIVE_MAX  = (1 << ACTIVE_W) - 1;
  localparam int ITEM_TARGET = 1900;
  localparam int CFG_TAIL    = 4;
  localparam int END_TAIL    = 1300;
  localparam int MAX_SHOWN   = 10;

  localparam cfg_reg_t LOW_REGS [3]  = '{REG_ROOM_X_LOW, REG_ROOM_Y_LOW, REG_ROOM_Z_LOW};
  localparam cfg_reg_t HIGH_REGS [3] = '{REG_ROOM_X_HIGH, REG_ROOM_Y_HIGH, REG_ROOM_Z_HIGH};

  typedef enum {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t  op;
    cfg_reg_t reg_idx;
    int       cfg_val;
    logic     kind;
    int       slot;
    int       pa [3];
    int       pb [3];
    bit       fixed;
    bit       fixed_val;
  } dir_row_t;

  typedef struct {
    bit collided;
    int seq;
  } collide_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = KIND_LOAD;
  logic [SLOT_W-1:0] in_box_slot = '0;
  logic signed [COORD_W-1:0] in_x_a = '0;
  logic signed [COORD_W-1:0] in_y_a = '0;
  logic signed [COORD_W-1:0] in_z_a = '0;
  logic signed [COORD_W-1:0] in_x_b = '0;
  logic signed [COORD_W-1:0] in_y_b = '0;
  logic signed [COORD_W-1:0] in_z_b = '0;
  logic out_valid;
  logic out_collided;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic row_fixed = 1'b0;
  logic row_fixed_val = 1'b0;

  longint box_tbl [N_BOXES][6];
  longint room_lo [3];
  longint room_hi [3];
  longint clr_radius;
  int     n_active;

  collide_rec_t collide_q [$];
  dir_row_t     dir_rows [$];

  int n_sent = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_hits = 0;
  int n_writes = 0;
  int n_phases = 0;
  int n_mismatch = 0;

  segment_box_collision_check DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_box_slot  (in_box_slot),
    .in_x_a       (in_x_a),
    .in_y_a       (in_y_a),
    .in_z_a       (in_z_a),
    .in_x_b       (in_x_b),
    .in_y_b       (in_y_b),
    .in_z_b       (in_z_b),
    .out_valid    (out_valid),
    .out_collided (out_collided),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("FAIL segment_box_collision_check");
    $finish;
  end

  function automatic bit in_wall_band(longint p, int k);
    return (p <= room_lo[k] + clr_radius) || (p >= room_hi[k] - clr_radius);
  endfunction

  function automatic bit segment_meets_box(longint pa [3], longint d [3], int j);
    longint near_n, near_d, far_n, far_d;
    longint lo, hi, n1, n2, den, tmin, tmax;
    near_n = 0;
    near_d = 1;
    far_n  = 1;
    far_d  = 1;
    for (int k = 0; k < 3; k++) begin
      lo = box_tbl[j][2*k] - clr_radius;
      hi = box_tbl[j][2*k+1] + clr_radius;
      if (d[k] == 0) begin
        if (pa[k] < lo || pa[k] > hi) return 1'b0;
      end else begin
        n1  = lo - pa[k];
        n2  = hi - pa[k];
        den = d[k];
        if (den < 0) begin
          n1  = -n1;
          n2  = -n2;
          den = -den;
        end
        tmin = (n1 < n2) ? n1 : n2;
        tmax = (n1 < n2) ? n2 : n1;
        if (tmin > den || tmax < 0) return 1'b0;
        if (tmin < 0) tmin = 0;
        if (tmax > den) tmax = den;
        if (tmin * near_d > near_n * den) begin
          near_n = tmin;
          near_d = den;
        end
        if (far_n * den > tmax * far_d) begin
          far_n = tmax;
          far_d = den;
        end
        if (near_n * far_d > far_n * near_d) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit predict_collision(longint pa [3], longint pb [3]);
    longint d [3];
    bit hit;
    int n;
    hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d[k] = pb[k] - pa[k];
      if (in_wall_band(pa[k], k) || in_wall_band(pb[k], k)) hit = 1'b1;
    end
    n = (n_active > N_BOXES) ? N_BOXES : n_active;
    for (int j = 0; j < n; j++)
      if (segment_meets_box(pa, d, j)) hit = 1'b1;
    return hit;
  endfunction

  always @(posedge clk) begin : monitor
    longint pa [3];
    longint pb [3];
    collide_rec_t rec;
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        room_lo[k] = COORD_MIN;
        room_hi[k] = COORD_MAX;
      end
      clr_radius = 0;
      n_active   = 0;
    end else begin
      if (out_valid) begin
        if (collide_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_SHOWN)
            $display("unexpected result strobe, collided %0b", out_collided);
        end else begin
          rec = collide_q.pop_front();
          if (out_collided !== rec.collided) begin
            n_mismatch++;
            if (n_mismatch <= MAX_SHOWN)
              $display("collided mismatch on query %0d: expected %0b, got %0b",
                       rec.seq, rec.collided, out_collided);
          end
        end
      end
      if (cfg_we) begin
        n_writes++;
        case (cfg_index)
          REG_ROOM_X_LOW:  room_lo[0] = longint'(signed'(cfg_data[COORD_W-1:0]));
          REG_ROOM_X_HIGH: room_hi[0] = longint'(signed'(cfg_data[COORD_W-1:0]));
          REG_ROOM_Y_LOW:  room_lo[1] = longint'(signed'(cfg_data[COORD_W-1:0]));
          REG_ROOM_Y_HIGH: room_hi[1] = longint'(signed'(cfg_data[COORD_W-1:0]));
          REG_ROOM_Z_LOW:  room_lo[2] = longint'(signed'(cfg_data[COORD_W-1:0]));
          REG_ROOM_Z_HIGH: room_hi[2] = longint'(signed'(cfg_data[COORD_W-1:0]));
          REG_RADIUS:      clr_radius = longint'(cfg_data[RADIUS_W-1:0]);
          REG_ACTIVE:      n_active   = int'(cfg_data[ACTIVE_W-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        pa[0] = longint'(in_x_a);
        pa[1] = longint'(in_y_a);
        pa[2] = longint'(in_z_a);
        pb[0] = longint'(in_x_b);
        pb[1] = longint'(in_y_b);
        pb[2] = longint'(in_z_b);
        if (in_kind == KIND_LOAD) begin
          n_loads++;
          for (int k = 0; k < 3; k++) begin
            box_tbl[in_box_slot][2*k]   = pa[k];
            box_tbl[in_box_slot][2*k+1] = pb[k];
          end
        end else begin
          n_queries++;
          rec.seq      = n_queries;
          rec.collided = row_fixed ? row_fixed_val : predict_collision(pa, pb);
          if (rec.collided) n_hits++;
          collide_q.push_back(rec);
        end
      end
    end
  end

  function automatic int clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return int'(v);
  endfunction

  function automatic int scene_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int full_coord();
    return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_MIN;
  endfunction

  function automatic dir_row_t row_item(logic kind, int slot, int ax, int ay, int az,
                                        int bx, int by, int bz, bit fixed, bit fixed_val);
    dir_row_t r;
    r.op        = ROW_ITEM;
    r.reg_idx   = REG_ROOM_X_LOW;
    r.cfg_val   = 0;
    r.kind      = kind;
    r.slot      = slot;
    r.pa        = '{ax, ay, az};
    r.pb        = '{bx, by, bz};
    r.fixed     = fixed;
    r.fixed_val = fixed_val;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(cfg_reg_t idx, int val);
    dir_row_t r;
    r         = row_item(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    r.op      = ROW_CFG;
    r.reg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic send_item(input logic kind, input int slot, input int pa [3],
                           input int pb [3], input bit fixed, input bit fixed_val);
    start         <= 1'b1;
    in_kind       <= kind;
    in_box_slot   <= slot[SLOT_W-1:0];
    in_x_a        <= pa[0][COORD_W-1:0];
    in_y_a        <= pa[1][COORD_W-1:0];
    in_z_a        <= pa[2][COORD_W-1:0];
    in_x_b        <= pb[0][COORD_W-1:0];
    in_y_b        <= pb[1][COORD_W-1:0];
    in_z_b        <= pb[2][COORD_W-1:0];
    row_fixed     <= fixed;
    row_fixed_val <= fixed_val;
    do @(posedge clk); while (busy);
    n_sent++;
    // hold off the next transaction, except during the no-idle stretch
    if (!(n_sent >= 700 && n_sent < 1000) && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain(input int tail);
    start <= 1'b0;
    @(posedge clk);
    while (collide_q.size() != 0 || busy) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_random_box(input int slot);
    int pa [3];
    int pb [3];
    int pick, c, h, ax, t;
    pick = $urandom_range(0, 99);
    for (int k = 0; k < 3; k++) begin
      if (pick < 85) begin
        c     = scene_coord();
        h     = $urandom_range(0, 8192);
        pa[k] = clamp_coord(longint'(c) - h);
        pb[k] = clamp_coord(longint'(c) + h);
      end else begin
        pa[k] = full_coord();
        pb[k] = full_coord();
      end
    end
    // swap one axis to get reversed bounds
    if (pick >= 75 && pick < 85) begin
      ax     = $urandom_range(0, 2);
      t      = pa[ax];
      pa[ax] = pb[ax];
      pb[ax] = t;
    end
    send_item(KIND_LOAD, slot, pa, pb, 1'b0, 1'b0);
  endtask

  task automatic query_random(input int n_eff);
    int pa [3];
    int pb [3];
    int pick, j;
    longint lo, hi, m;
    pick = $urandom_range(0, 99);
    j    = (n_eff > 0) ? int'($urandom_range(0, n_eff - 1)) : int'($urandom_range(0, N_BOXES - 1));
    for (int k = 0; k < 3; k++) begin
      if (pick < 60) begin
        lo = (box_tbl[j][2*k] < box_tbl[j][2*k+1]) ? box_tbl[j][2*k] : box_tbl[j][2*k+1];
        hi = (box_tbl[j][2*k] < box_tbl[j][2*k+1]) ? box_tbl[j][2*k+1] : box_tbl[j][2*k];
        m  = clr_radius + 4096;
        pa[k] = clamp_coord(lo - m + longint'($urandom_range(0, int'(hi - lo + 2 * m))));
        pb[k] = clamp_coord(lo - m + longint'($urandom_range(0, int'(hi - lo + 2 * m))));
        if ($urandom_range(0, 99) < 15) pb[k] = pa[k];
      end else if (pick < 90) begin
        pa[k] = scene_coord();
        pb[k] = scene_coord();
      end else begin
        pa[k] = full_coord();
        pb[k] = full_coord();
      end
    end
    if ($urandom_range(0, 99) < 4) pb = pa;
    send_item(KIND_QUERY, $urandom_range(0, N_BOXES - 1), pa, pb, 1'b0, 1'b0);
  endtask

  task automatic program_phase(input int p, output int act);
    int pick, lo, hi;
    for (int k = 0; k < 3; k++) begin
      pick = (p % 7 == 2) ? 70 : int'($urandom_range(0, 99));
      if (pick < 65) begin
        lo = COORD_MIN + int'($urandom_range(0, 8192));
        hi = COORD_MAX - int'($urandom_range(0, 8192));
      end else if (pick < 80) begin
        lo = COORD_MIN;
        hi = COORD_MAX;
      end else if (pick < 95) begin
        lo = -int'($urandom_range(40000, 200000));
        hi = int'($urandom_range(40000, 200000));
      end else begin
        lo = int'($urandom_range(0, 20000));
        hi = -int'($urandom_range(0, 20000));
      end
      write_reg(LOW_REGS[k], lo);
      write_reg(HIGH_REGS[k], hi);
    end
    pick = $urandom_range(0, 99);
    if (p % 9 == 4)     write_reg(REG_RADIUS, RADIUS_MAX);
    else if (pick < 20) write_reg(REG_RADIUS, 0);
    else if (pick < 75) write_reg(REG_RADIUS, $urandom_range(1, 4096));
    else if (pick < 92) write_reg(REG_RADIUS, $urandom_range(4097, 65536));
    else                write_reg(REG_RADIUS, $urandom_range(0, RADIUS_MAX));
    if (p % 8 == 5)
      act = (p % 16 == 5) ? N_BOXES : int'($urandom_range(N_BOXES + 1, ACTIVE_MAX));
    else if (p % 10 == 3)
      act = 0;
    else
      act = $urandom_range(1, 8);
    write_reg(REG_ACTIVE, act);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int act, n_eff, n_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, 0, 0, 100, 100, 100, 1'b1, 1'b0));
    dir_rows.push_back(row_item(KIND_QUERY, 0, COORD_MIN, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, COORD_MAX, 1'b1, 1'b1));
    dir_rows.push_back(row_item(KIND_LOAD, 0, -4096, -4096, -4096, 4096, 4096, 4096,
                                1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_LOAD, 1, 8192, 20000, -4096, 4096, 30000, 4096,
                                1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_LOAD, 2, 200000, 200000, 200000, 210000, 210000,
                                210000, 1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_LOAD, N_BOXES - 1, COORD_MIN, COORD_MIN, COORD_MIN,
                                COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0));
    dir_rows.push_back(row_cfg(REG_ACTIVE, 3));
    dir_rows.push_back(row_item(KIND_QUERY, 0, -20000, 0, 0, 20000, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_QUERY, 0, -20000, 50000, 0, 20000, 50000, 0,
                                1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 100, 200, 300, 100, 200, 300, 1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 4096, 0, 0, 20000, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, 25000, 0, 10000, 25000, 0, 1'b0, 1'b0));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 6000, 25000, 0, 6000, 26000, 0, 1'b0, 1'b0));
    dir_rows.push_back(row_cfg(REG_RADIUS, RADIUS_MAX));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    dir_rows.push_back(row_cfg(REG_RADIUS, 1000));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 5000, 0, 0, 6000, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(row_cfg(REG_ROOM_X_LOW, 1000));
    dir_rows.push_back(row_cfg(REG_ROOM_X_HIGH, -1000));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, 0, 0, 1, 1, 1, 1'b1, 1'b1));
    dir_rows.push_back(row_cfg(REG_ROOM_X_LOW, COORD_MIN));
    dir_rows.push_back(row_cfg(REG_ROOM_X_HIGH, COORD_MAX));
    dir_rows.push_back(row_cfg(REG_ROOM_Y_LOW, -100000));
    dir_rows.push_back(row_cfg(REG_ROOM_Y_HIGH, 100000));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, -99000, 0, 0, 0, 0, 1'b1, 1'b1));
    dir_rows.push_back(row_item(KIND_QUERY, 0, 0, -98999, 0, 0, 0, 0, 1'b0, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        drain(CFG_TAIL);
        write_reg(dir_rows[i].reg_idx, dir_rows[i].cfg_val);
        cfg_we <= 1'b0;
      end else begin
        send_item(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].pa, dir_rows[i].pb,
                  dir_rows[i].fixed, dir_rows[i].fixed_val);
      end
    end

    // fill the whole table before any query can reach it
    drain(CFG_TAIL);
    for (int s = 0; s < N_BOXES; s++) load_random_box(s);

    while (n_sent < ITEM_TARGET) begin
      drain(CFG_TAIL);
      program_phase(n_phases, act);
      n_eff   = (act > N_BOXES) ? N_BOXES : act;
      n_items = (act >= N_BOXES) ? 25 : 80;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 30) load_random_box($urandom_range(0, N_BOXES - 1));
        else query_random(n_eff);
      end
      n_phases++;
    end

    drain(END_TAIL);
    n_mismatch += collide_q.size();
    $display("covered %0d loads and %0d queries, %0d of them collided",
             n_loads, n_queries, n_hits);
    $display("%0d register writes over %0d random phases, %0d mismatches",
             n_writes, n_phases, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASS segment_box_collision_check");
    end else begin
      $display("FAIL segment_box_collision_check");
    end
    $finish;
  end

endmodule
